/* src/tlm_pkg.sv */
// Package for the task load monitor: constants, codes and controller/datapath types.
package tlm_pkg;

    // Default number of tracked tasks
    localparam int TASK_COUNT_DEF = 8;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int TASK_W   = 8;
    localparam int TIME_W   = 32;
    localparam int LOAD_W   = 8;

    // Load scaling and saturation
    localparam int unsigned LOAD_SCALE = 100;
    localparam int unsigned LOAD_MAX   = 255;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLK_IN   = 2'd0,
        ACT_CLK_OUT  = 2'd1,
        ACT_PERIODIC = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_STORE,
        ST_FIN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic div_start;
        logic store;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_action action;
        logic    last_idx;
        logic    div_done;
        logic    out_busy;
    } t_dp_status;

endpackage

/* src/tlm_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module tlm_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tlm_pkg::TIME_W-1:0] i_dividend,
    input  logic [tlm_pkg::TIME_W-1:0] i_divisor,
    output logic [tlm_pkg::TIME_W-1:0] o_quotient,
    output logic                       o_done
);
    import tlm_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_quo;
    logic [TIME_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_sub;
    logic              ge;

    // One shift-and-subtract step
    always_comb begin
        rem_sh  = {r_rem, r_quo[TIME_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[TIME_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* src/tlm_datapath.sv */
// Datapath: accumulators, load store, interval, product, divider and output word.
module tlm_datapath #(
    parameter int TASK_COUNT = tlm_pkg::TASK_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlm_pkg::t_dp_cmd             i_cmd,
    output tlm_pkg::t_dp_status          o_status,
    input  logic [tlm_pkg::ACTION_W-1:0] i_action,
    input  logic [tlm_pkg::TASK_W-1:0]   i_task_req,
    input  logic [tlm_pkg::TIME_W-1:0]   i_now,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [tlm_pkg::LOAD_W-1:0]   o_load_percent
);
    import tlm_pkg::*;

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    logic [TIME_W-1:0] r_acc  [TASK_COUNT];
    logic [LOAD_W-1:0] r_load [TASK_COUNT];
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] r_interval;
    logic [TIME_W-1:0] r_prod;
    logic [IDX_W-1:0]  r_idx;

    t_action           r_action;
    logic [IDX_W-1:0]  r_task;
    logic              r_task_ok;
    logic [TIME_W-1:0] r_now;
    logic [LOAD_W-1:0] r_result;

    logic              r_out_valid;
    logic [LOAD_W-1:0] r_out_data;

    logic [TIME_W-1:0] quotient;
    logic              div_done;
    logic [LOAD_W-1:0] load_sat;
    logic              last_idx;

    tlm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_interval),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // Saturate quotient; zero interval gives no load
    always_comb begin
        if (r_interval == '0) begin
            load_sat = '0;
        end else if (quotient > TIME_W'(LOAD_MAX)) begin
            load_sat = LOAD_W'(LOAD_MAX);
        end else begin
            load_sat = quotient[LOAD_W-1:0];
        end
        last_idx = r_idx == IDX_W'(TASK_COUNT - 1);
    end

    // Capture of the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action  <= t_action'(i_action);
            r_task    <= i_task_req[IDX_W-1:0];
            r_task_ok <= i_task_req < TASK_W'(TASK_COUNT);
            r_now     <= i_now;
        end
    end

    // Architectural state: accumulators, load store, last update time, sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_acc[i]  <= '0;
                r_load[i] <= '0;
            end
            r_prev <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_action)
                    ACT_CLK_IN: begin
                        if (r_task_ok) r_acc[r_task] <= r_acc[r_task] - r_now;
                    end
                    ACT_CLK_OUT: begin
                        if (r_task_ok) r_acc[r_task] <= r_acc[r_task] + r_now;
                    end
                    ACT_PERIODIC: begin
                        r_prev <= r_now;
                        r_idx  <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.store) begin
                r_load[r_idx] <= load_sat;
                r_acc[r_idx]  <= '0;
                if (!last_idx) r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Interval, scaled product and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_interval <= r_now - r_prev;
            if (r_action == ACT_READ && r_task_ok) begin
                r_result <= r_load[r_task];
            end else begin
                r_result <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= TIME_W'(r_acc[r_idx] * TIME_W'(LOAD_SCALE));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out_data <= r_result;
    end

    assign o_status.action   = r_action;
    assign o_status.last_idx = last_idx;
    assign o_status.div_done = div_done;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_load_percent = r_out_data;

endmodule

/* src/tlm_ctrl.sv */
// Controller state machine: sequences accept, update, periodic sweep and output.
module tlm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output tlm_pkg::t_dp_cmd    o_cmd,
    input  tlm_pkg::t_dp_status i_status
);
    import tlm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC:  n_state = (i_status.action == ACT_PERIODIC) ? ST_MUL : ST_FIN;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   n_state = ST_WAIT;
            ST_WAIT:  if (i_status.div_done) n_state = ST_STORE;
            ST_STORE: n_state = i_status.last_idx ? ST_FIN : ST_MUL;
            ST_FIN:   if (!i_status.out_busy) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC:  o_cmd.exec = 1'b1;
            ST_MUL:   o_cmd.mul = 1'b1;
            ST_DIV:   o_cmd.div_start = 1'b1;
            ST_STORE: o_cmd.store = 1'b1;
            ST_FIN:   o_cmd.out_load = !i_status.out_busy;
            default: ;
        endcase
    end

endmodule

/* src/task_load_monitor.sv */
// Task load monitor: per-task busy time accounting and load percent readout.
// Clock-in, clock-out and read words: the result is loaded into the output register in the finish
// state; one word in flight at a time, so a new word is taken only after that load, and a result
// not taken holds the monitor in the finish state. A periodic update sweeps the tasks through one
// shared divider, one task at a time (multiply, divide, wait, store), then loads its result word.
// Synchronous active-low reset clears accumulators, load store and last update time.
module task_load_monitor #(
    parameter int TASK_COUNT = tlm_pkg::TASK_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tlm_pkg::ACTION_W-1:0] i_action,
    input  logic [tlm_pkg::TASK_W-1:0]   i_task_req,
    input  logic [tlm_pkg::TIME_W-1:0]   i_now,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tlm_pkg::LOAD_W-1:0]   o_load_percent
);
    import tlm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    tlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    tlm_datapath #(
        .TASK_COUNT (TASK_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_task_req     (i_task_req),
        .i_now          (i_now),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_load_percent (o_load_percent)
    );

endmodule
